// File: hdl/srtf_pkg.sv
// Shared types and constants for the shortest-remaining-time-first scheduler.
package srtf_pkg;

    // Slot numbers are carried at the width of the largest supported table.
    localparam int SLOT_W = 8;
    localparam int REM_W  = 16;
    localparam int TIME_W = 32;
    localparam int ID_W   = 8;

    typedef enum logic [2:0] {
        KIND_ADDED    = 3'd0,
        KIND_REJECTED = 3'd1,
        KIND_IDLE     = 3'd2,
        KIND_RAN      = 3'd3,
        KIND_FINISHED = 3'd4
    } kind_t;

    typedef enum logic [0:0] {
        REQ_ADD  = 1'b0,
        REQ_TICK = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    // Running best entry and lowest free slot, passed from cell to cell.
    typedef struct packed {
        logic              best_valid;
        logic [REM_W-1:0]  best_rem;
        logic [TIME_W-1:0] best_arr;
        logic [ID_W-1:0]   best_id;
        logic [SLOT_W-1:0] best_slot;
        logic              free_found;
        logic [SLOT_W-1:0] free_slot;
    } cand_t;

    // Update broadcast from the controller to every cell.
    typedef struct packed {
        logic              en;
        logic              is_add;
        logic [SLOT_W-1:0] slot;
        logic [REM_W-1:0]  burst;
        logic [TIME_W-1:0] arrival;
        logic [ID_W-1:0]   id;
    } commit_t;

endpackage

// File: hdl/srtf_scheduler_top.sv
// Top level of the shortest-remaining-time-first scheduler: control, time and output register.
//
// Input channel (in_valid / in_stall) carries one request item: req_type 0 adds a process
// (proc_id, burst_time) stamped with the current time, req_type 1 is one time tick.
// Output channel (out_valid / out_stall) returns exactly one result item per request:
// result_kind, served_id and finish_time (the time after the item).
// Each slot of the table lives in its own cell; the cells form a chain through which the
// best runnable entry and the lowest free slot travel, one cell per clock.
// An item's result is registered once the scan has let the chain settle and the commit
// step has run. A new item is taken only in the idle state, so the block does not accept
// a new item before the last one is committed; the chain length sets the scan length.
// in_stall is high while an item is being worked on. A finished result sits in the
// output register while the next item is accepted and scanned; if the receiver still
// stalls when that next result is ready, the block waits before committing it.
// Reset empties the table and sets the time to zero; no clearing pass is needed.
module srtf_scheduler_top #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [0:0]  req_type,
    input  logic [7:0]  proc_id,
    input  logic [15:0] burst_time,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  result_kind,
    output logic [7:0]  served_id,
    output logic [31:0] finish_time
);

    localparam int CNT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    srtf_pkg::state_t            state_reg;
    srtf_pkg::state_t            state_next;
    logic [CNT_W-1:0]            cnt_reg;
    logic [CNT_W-1:0]            cnt_next;
    logic [srtf_pkg::TIME_W-1:0] now_reg;
    logic [srtf_pkg::TIME_W-1:0] now_next;
    srtf_pkg::req_t              req_reg;
    logic [srtf_pkg::ID_W-1:0]   pid_reg;
    logic [srtf_pkg::REM_W-1:0]  burst_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    srtf_pkg::kind_t             kind_reg;
    srtf_pkg::kind_t             kind_next;
    logic [srtf_pkg::ID_W-1:0]   sid_reg;
    logic [srtf_pkg::ID_W-1:0]   sid_next;
    logic [srtf_pkg::TIME_W-1:0] ftime_reg;
    logic [srtf_pkg::TIME_W-1:0] ftime_next;

    logic              in_fire;
    logic              out_free;
    srtf_pkg::commit_t commit;
    srtf_pkg::cand_t   chain [TABLE_ENTRIES+1];
    srtf_pkg::cand_t   result;

    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != srtf_pkg::ST_IDLE);
    assign result   = chain[TABLE_ENTRIES];

    assign chain[0] = '{best_valid: 1'b0, best_rem: '0, best_arr: '0, best_id: '0,
                        best_slot: '0, free_found: 1'b0, free_slot: '0};

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++)
        begin : g_cell
            srtf_cell #(
                .CELL_IDX (g)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cand_in  (chain[g]),
                .commit   (commit),
                .cand_out (chain[g+1])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        now_next       = now_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        sid_next       = sid_reg;
        ftime_next     = ftime_reg;
        commit         = '{en: 1'b0, is_add: 1'b0, slot: '0, burst: burst_reg,
                           arrival: now_reg, id: pid_reg};

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            srtf_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = srtf_pkg::ST_SCAN;
                    cnt_next   = '0;
                end
            end
            srtf_pkg::ST_SCAN:
            begin
                // The chain has settled once every cell has been clocked since the last update.
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(TABLE_ENTRIES - 1))
                    state_next = srtf_pkg::ST_COMMIT;
            end
            srtf_pkg::ST_COMMIT:
            begin
                if (out_free)
                begin
                    state_next     = srtf_pkg::ST_IDLE;
                    out_valid_next = 1'b1;
                    if (req_reg == srtf_pkg::REQ_ADD)
                    begin
                        sid_next   = pid_reg;
                        ftime_next = now_reg;
                        if (burst_reg == '0 || !result.free_found)
                            kind_next = srtf_pkg::KIND_REJECTED;
                        else
                        begin
                            kind_next     = srtf_pkg::KIND_ADDED;
                            commit.en     = 1'b1;
                            commit.is_add = 1'b1;
                            commit.slot   = result.free_slot;
                        end
                    end
                    else
                    begin
                        now_next   = now_reg + srtf_pkg::TIME_W'(1);
                        ftime_next = now_reg + srtf_pkg::TIME_W'(1);
                        if (!result.best_valid)
                        begin
                            kind_next = srtf_pkg::KIND_IDLE;
                            sid_next  = '0;
                        end
                        else
                        begin
                            sid_next    = result.best_id;
                            commit.en   = 1'b1;
                            commit.slot = result.best_slot;
                            if (result.best_rem == srtf_pkg::REM_W'(1))
                                kind_next = srtf_pkg::KIND_FINISHED;
                            else
                                kind_next = srtf_pkg::KIND_RAN;
                        end
                    end
                end
            end
            default:
            begin
                state_next = srtf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srtf_pkg::ST_IDLE;
            cnt_reg       <= '0;
            now_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            now_reg       <= now_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg   <= srtf_pkg::req_t'(req_type);
            pid_reg   <= proc_id;
            burst_reg <= burst_time;
        end
        kind_reg  <= kind_next;
        sid_reg   <= sid_next;
        ftime_reg <= ftime_next;
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign served_id   = sid_reg;
    assign finish_time = ftime_reg;

    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == srtf_pkg::ST_SCAN)
        else $error("accepted item did not start a scan");

    a_commit_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == srtf_pkg::ST_COMMIT && out_free) |=> out_valid_reg)
        else $error("commit did not load the output register");

    a_time_steps_by_one: assert property (@(posedge clk) disable iff (!rst_n)
        (now_reg != $past(now_reg)) |-> (now_reg == $past(now_reg) + srtf_pkg::TIME_W'(1)))
        else $error("time moved by other than one");

    a_kind_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (kind_reg == srtf_pkg::KIND_ADDED || kind_reg == srtf_pkg::KIND_REJECTED
                           || kind_reg == srtf_pkg::KIND_IDLE || kind_reg == srtf_pkg::KIND_RAN
                           || kind_reg == srtf_pkg::KIND_FINISHED))
        else $error("result kind out of range");

endmodule

// File: hdl/srtf_cell.sv
// One table slot of the scheduler with its stage of the candidate chain.
module srtf_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  srtf_pkg::cand_t   cand_in,
    input  srtf_pkg::commit_t commit,
    output srtf_pkg::cand_t   cand_out
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [srtf_pkg::REM_W-1:0]  rem_reg;
    logic [srtf_pkg::REM_W-1:0]  rem_next;
    logic [srtf_pkg::TIME_W-1:0] arr_reg;
    logic [srtf_pkg::TIME_W-1:0] arr_next;
    logic [srtf_pkg::ID_W-1:0]   id_reg;
    logic [srtf_pkg::ID_W-1:0]   id_next;
    srtf_pkg::cand_t             cand_reg;
    srtf_pkg::cand_t             cand_next;

    logic [srtf_pkg::SLOT_W-1:0] my_slot;
    logic                        mine_wins;
    logic                        hit;

    assign my_slot = srtf_pkg::SLOT_W'(CELL_IDX);
    assign hit     = commit.en && (commit.slot == my_slot);

    // Strict comparison, so on a full tie the lower slot coming in keeps its place.
    always_comb
    begin
        mine_wins = 1'b0;
        if (valid_reg)
        begin
            if (!cand_in.best_valid)
                mine_wins = 1'b1;
            else if (rem_reg != cand_in.best_rem)
                mine_wins = rem_reg < cand_in.best_rem;
            else if (arr_reg != cand_in.best_arr)
                mine_wins = arr_reg < cand_in.best_arr;
            else
                mine_wins = id_reg < cand_in.best_id;
        end
    end

    always_comb
    begin
        cand_next = cand_in;
        if (mine_wins)
        begin
            cand_next.best_valid = 1'b1;
            cand_next.best_rem   = rem_reg;
            cand_next.best_arr   = arr_reg;
            cand_next.best_id    = id_reg;
            cand_next.best_slot  = my_slot;
        end
        if (!cand_in.free_found && !valid_reg)
        begin
            cand_next.free_found = 1'b1;
            cand_next.free_slot  = my_slot;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        rem_next   = rem_reg;
        arr_next   = arr_reg;
        id_next    = id_reg;
        if (hit)
        begin
            if (commit.is_add)
            begin
                valid_next = 1'b1;
                rem_next   = commit.burst;
                arr_next   = commit.arrival;
                id_next    = commit.id;
            end
            else
            begin
                rem_next = rem_reg - srtf_pkg::REM_W'(1);
                if (rem_reg == srtf_pkg::REM_W'(1))
                    valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        arr_reg  <= arr_next;
        id_reg   <= id_next;
        cand_reg <= cand_next;
    end

    assign cand_out = cand_reg;

endmodule
